/* hw/rtl/mtg_pkg.sv */
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and word functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int ADDR_W        = 10;
  localparam int WORD_W        = 32;
  localparam int SKIP_W        = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int DIV_STEPS     = WORD_W;
  localparam int DIV_CNT_W     = 6;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SKIP_W-1:0] skip_t;

  localparam word_t INIT_MULT = 32'h6c078965;
  localparam word_t TWIST_XOR = 32'h9908b0df;
  localparam word_t TEMPER_B  = 32'h9d2c5680;
  localparam word_t TEMPER_C  = 32'hefc60000;
  localparam word_t HIGH_BIT  = 32'h80000000;
  localparam word_t LOW_BITS  = 32'h7fffffff;

  localparam addr_t LAST_ADDR = addr_t'(STATE_WORDS - 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_SEED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SKIP = 2'd1;

  // One access to the state memory per cycle: write, or read at addr.
  typedef struct packed {
    logic  wr_en;
    addr_t addr;
    word_t wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t remainder;
  } div_rsp_t;

  function automatic addr_t next_addr(input addr_t a);
    if (a == LAST_ADDR) begin
      return '0;
    end
    return a + addr_t'(1);
  endfunction

  function automatic addr_t mid_addr(input addr_t a);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + (ADDR_W+1)'(MIDDLE_OFFSET);
    if (s >= (ADDR_W+1)'(STATE_WORDS)) begin
      s = s - (ADDR_W+1)'(STATE_WORDS);
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic word_t twist(input word_t cur, input word_t nxt, input word_t mid);
    word_t y;
    word_t v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = mid ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_XOR;
    end
    return v;
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* hw/rtl/mtg_state_ram.sv */
// ----------------------------------------------------------------------------
// mtg_state_ram
// Single-port state memory, 624 x 32, registered read data.
// ----------------------------------------------------------------------------
module mtg_state_ram
  import mtg_pkg::*;
(
  input  logic     clk,
  input  mem_cmd_t cmd,
  output word_t    rdata
);

  word_t mem [STATE_WORDS];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    rdata <= mem[cmd.addr];
  end

endmodule

/* hw/rtl/mtg_mod_unit.sv */
// ----------------------------------------------------------------------------
// mtg_mod_unit
// Restoring 32-bit remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtg_mod_unit
  import mtg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  word_t                rem;
  word_t                rem_next;
  word_t                quo;
  word_t                divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [WORD_W:0]      trial;

  always_comb begin
    trial = {rem, quo[WORD_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = trial[WORD_W-1:0] - divisor;
    end else begin
      rem_next = trial[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
        cnt     <= DIV_CNT_W'(DIV_STEPS);
        busy    <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo << 1;
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

/* hw/rtl/mt19937_generator.sv */
// ----------------------------------------------------------------------------
// mt19937_generator
// MT19937 generator with the 624-word state in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  in      | in_valid / in_ready   | mode, range_limit
//  out     | out_valid / out_ready | number
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A draw reads the current, next and middle words through the single memory
// port in S_RD_CUR, S_RD_NXT and S_RD_MID, twists the current word in place
// in S_TWIST and tempers it; a nonzero range then takes it through the
// 32-step remainder unit, a zero range returns the tempered word.
// A reseed writes the 624 words: word 0 from the seed, each further word in
// two steps (multiply, then add and write); it then runs the skipped draws.
// Reset clears the state, the index, the seed and skip settings, out_valid.
// A new item is taken while a finished result still waits in the output
// register; the next result holds until that one is taken.
// ----------------------------------------------------------------------------
module mt19937_generator
  import mtg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [31:0]            range_limit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            number,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SEED0     = 4'd1;
  localparam logic [3:0] S_SEED_MUL  = 4'd2;
  localparam logic [3:0] S_SEED_WR   = 4'd3;
  localparam logic [3:0] S_SKIP_CHK  = 4'd4;
  localparam logic [3:0] S_RD_CUR    = 4'd5;
  localparam logic [3:0] S_RD_NXT    = 4'd6;
  localparam logic [3:0] S_RD_MID    = 4'd7;
  localparam logic [3:0] S_TWIST     = 4'd8;
  localparam logic [3:0] S_DIV_START = 4'd9;
  localparam logic [3:0] S_DIV_WAIT  = 4'd10;
  localparam logic [3:0] S_FINISH    = 4'd11;

  logic [3:0] state;
  addr_t      word_index;
  addr_t      seed_k;
  word_t      seed_value;
  skip_t      skip_count;
  skip_t      skip_left;
  logic       discard;
  logic       item_mode;
  word_t      item_range;
  word_t      prev_word;
  word_t      prod;
  word_t      cur_word;
  word_t      nxt_word;
  word_t      result;
  word_t      rdata;
  word_t      seed_word;
  word_t      twist_word;
  mem_cmd_t   cmd;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  mtg_state_ram u_ram (
    .clk   (clk),
    .cmd   (cmd),
    .rdata (rdata)
  );

  mtg_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign seed_word  = prod + word_t'(seed_k);
  assign twist_word = twist(cur_word, nxt_word, rdata);

  assign div_req.start    = (state == S_DIV_START);
  assign div_req.dividend = result;
  assign div_req.divisor  = item_range;

  always_comb begin
    cmd.wr_en = 1'b0;
    cmd.addr  = word_index;
    cmd.wdata = seed_word;
    case (state)
      S_SEED0: begin
        cmd.wr_en = 1'b1;
        cmd.addr  = '0;
        cmd.wdata = seed_value;
      end
      S_SEED_WR: begin
        cmd.wr_en = 1'b1;
        cmd.addr  = seed_k;
      end
      S_RD_NXT: begin
        cmd.addr = next_addr(word_index);
      end
      S_RD_MID: begin
        cmd.addr = mid_addr(word_index);
      end
      S_TWIST: begin
        // words behind the index are already twisted, as a full pass would leave them
        cmd.wr_en = 1'b1;
        cmd.wdata = twist_word;
      end
      default: begin
        cmd.wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_index <= '0;
      seed_value <= '0;
      skip_count <= '0;
      discard    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEED: seed_value <= cfg_data;
          CFG_SKIP: skip_count <= cfg_data[SKIP_W-1:0];
          default:  seed_value <= seed_value;
        endcase
      end

      // load a finished result, or drop the one just taken
      if (state == S_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_mode  <= mode;
            item_range <= range_limit;
            discard    <= 1'b0;
            state      <= mode ? S_SEED0 : S_RD_CUR;
          end
        end
        S_SEED0: begin
          prev_word <= seed_value;
          seed_k    <= addr_t'(1);
          state     <= S_SEED_MUL;
        end
        S_SEED_MUL: begin
          prod  <= INIT_MULT * (prev_word ^ (prev_word >> 30));
          state <= S_SEED_WR;
        end
        S_SEED_WR: begin
          prev_word <= seed_word;
          if (seed_k == LAST_ADDR) begin
            word_index <= '0;
            skip_left  <= skip_count;
            state      <= S_SKIP_CHK;
          end else begin
            seed_k <= seed_k + addr_t'(1);
            state  <= S_SEED_MUL;
          end
        end
        S_SKIP_CHK: begin
          if (skip_left == '0) begin
            result <= '0;
            state  <= S_FINISH;
          end else begin
            skip_left <= skip_left - skip_t'(1);
            discard   <= 1'b1;
            state     <= S_RD_CUR;
          end
        end
        S_RD_CUR: begin
          state <= S_RD_NXT;
        end
        S_RD_NXT: begin
          cur_word <= rdata;
          state    <= S_RD_MID;
        end
        S_RD_MID: begin
          nxt_word <= rdata;
          state    <= S_TWIST;
        end
        S_TWIST: begin
          word_index <= next_addr(word_index);
          result     <= temper(twist_word);
          if (discard) begin
            state <= S_SKIP_CHK;
          end else if (item_range == '0) begin
            state <= S_FINISH;
          end else begin
            state <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            result <= div_rsp.remainder;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            number <= item_mode ? '0 : result;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/mtg_checker.sv */
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks of the MT19937 generator, bound to the top level.
// ----------------------------------------------------------------------------
module mtg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        mode,
  input logic [31:0] range_limit,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] number
);

  logic        pend_mode;
  logic [31:0] pend_range;
  logic        prev_out_valid;
  logic        prev_out_ready;
  logic        new_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_out_valid <= 1'b0;
      prev_out_ready <= 1'b0;
    end else begin
      prev_out_valid <= out_valid;
      prev_out_ready <= out_ready;
    end
    if (in_valid && in_ready) begin
      pend_mode  <= mode;
      pend_range <= range_limit;
    end
  end

  // a result that shows up this cycle belongs to the last accepted item
  assign new_out = out_valid && (!prev_out_valid || prev_out_ready);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid not cleared by reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(number))
    else $error("result dropped or changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reseed_zero: assert property (@(posedge clk) disable iff (rst)
    new_out && pend_mode |-> number == 32'd0)
    else $error("reseed item returned a nonzero number");

  a_draw_in_range: assert property (@(posedge clk) disable iff (rst)
    new_out && !pend_mode && pend_range != 32'd0 |-> number < pend_range)
    else $error("draw result not below its range");

endmodule

bind mt19937_generator mtg_checker u_mtg_checker (.*);
